### design/llp_pkg.sv
`timescale 1ns / 1ps
package llp_pkg;
  localparam int DEF_MAX_TERMINALS    = 32;
  localparam int DEF_MAX_NONTERMINALS = 32;
  localparam int DEF_MAX_RULE_LENGTH  = 8;
  localparam int DEF_STACK_DEPTH      = 64;

  localparam logic [1:0] CMD_RULE_SYM = 2'd0;
  localparam logic [1:0] CMD_CELL_LEN = 2'd1;
  localparam logic [1:0] CMD_START    = 2'd2;
  localparam logic [1:0] CMD_TOKEN    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_NORULE   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_IDLE     = 3'd6;
  localparam logic [2:0] ST_LIMIT    = 3'd7;

  localparam logic [7:0] REG_TCOUNT = 8'd0;
  localparam logic [7:0] REG_NCOUNT = 8'd1;
  localparam logic [7:0] REG_START  = 8'd2;
  localparam logic [7:0] REG_LIMIT  = 8'd3;

  localparam logic [5:0] RST_TCOUNT = 6'd32;
  localparam logic [5:0] RST_NCOUNT = 6'd32;
  localparam logic [4:0] RST_START  = 5'd0;
  localparam logic [7:0] RST_LIMIT  = 8'd64;

  localparam logic [5:0] END_MARK = 6'd0;

  typedef struct packed {
    logic       latch_in;
    logic       tbl_write;
    logic       stk_init0;
    logic       stk_init1;
    logic       cell_rd;
    logic       push_wr;
    logic       clr_wr;
    logic       pop;
    logic       load_i;
    logic       exp_inc;
    logic       emit;
    logic       end_parse;
    logic [2:0] emit_status;
  } llp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       active;
    logic       tok_bad;
    logic       sp_zero;
    logic       top_is_nt;
    logic       top_bad;
    logic       top_mismatch;
    logic       top_end;
    logic       limit_hit;
    logic       no_rule;
    logic       overflow;
    logic       i_zero;
    logic       clr_done;
  } llp_sts_t;
endpackage

### design/ll1_table_driven_parser.sv
`timescale 1ns / 1ps
// Order: a table write is answered from dispatch, a start request from the stack-init state;
// a token is answered from dispatch when idle or unknown, else after the stack read, and
// each expansion adds a cell lookup and a push write per symbol.
// Requests: one at a time; the next start is taken once busy falls.
// Tokens step through the registered symbol-stack read, cell lookup and production memory read.
// Reset (synchronous, rst_n low) starts a clearing pass over all MAX_NONTERMINALS * MAX_TERMINALS
// cells of the cell table, busy high; the receiver cannot stall results.
module ll1_table_driven_parser #(
  parameter int MAX_TERMINALS    = llp_pkg::DEF_MAX_TERMINALS,
  parameter int MAX_NONTERMINALS = llp_pkg::DEF_MAX_NONTERMINALS,
  parameter int MAX_RULE_LENGTH  = llp_pkg::DEF_MAX_RULE_LENGTH,
  parameter int STACK_DEPTH      = llp_pkg::DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_row_nonterminal,
  input  logic [4:0] in_column_terminal,
  input  logic [2:0] in_rule_position,
  input  logic [5:0] in_rule_symbol,
  input  logic [3:0] in_rule_length,
  input  logic       in_has_rule,
  input  logic [4:0] in_token,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [7:0] out_expansions,
  output logic [6:0] out_stack_level,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import llp_pkg::*;

  llp_cmd_t cmd;
  llp_sts_t sts;

  // Configuration writes are always taken; they land in the datapath registers.
  assign cfg_ready = 1'b1;

  // The controller walks each request through dispatch and, for parse work, stack reads,
  // cell lookups and symbol pushes.
  llp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  // The datapath owns the stack, the parse table memories and the result register.
  llp_datapath #(
    .MAX_TERMINALS(MAX_TERMINALS),
    .MAX_NONTERMINALS(MAX_NONTERMINALS),
    .MAX_RULE_LENGTH(MAX_RULE_LENGTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_cmd(in_cmd), .in_row_nonterminal(in_row_nonterminal),
    .in_column_terminal(in_column_terminal), .in_rule_position(in_rule_position),
    .in_rule_symbol(in_rule_symbol), .in_rule_length(in_rule_length),
    .in_has_rule(in_has_rule), .in_token(in_token),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_status(out_status),
    .out_expansions(out_expansions), .out_stack_level(out_stack_level)
  );
endmodule

### design/llp_ram.sv
`timescale 1ns / 1ps
module llp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### design/llp_datapath.sv
`timescale 1ns / 1ps
module llp_datapath #(
  parameter int MAX_TERMINALS    = llp_pkg::DEF_MAX_TERMINALS,
  parameter int MAX_NONTERMINALS = llp_pkg::DEF_MAX_NONTERMINALS,
  parameter int MAX_RULE_LENGTH  = llp_pkg::DEF_MAX_RULE_LENGTH,
  parameter int STACK_DEPTH      = llp_pkg::DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  llp_pkg::llp_cmd_t cmd,
  output llp_pkg::llp_sts_t sts,
  input  logic [1:0]        in_cmd,
  input  logic [4:0]        in_row_nonterminal,
  input  logic [4:0]        in_column_terminal,
  input  logic [2:0]        in_rule_position,
  input  logic [5:0]        in_rule_symbol,
  input  logic [3:0]        in_rule_length,
  input  logic              in_has_rule,
  input  logic [4:0]        in_token,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [7:0]        out_expansions,
  output logic [6:0]        out_stack_level
);
  import llp_pkg::*;

  localparam int CELLS = MAX_NONTERMINALS * MAX_TERMINALS;
  localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RULES = CELLS * MAX_RULE_LENGTH;
  localparam int RAW   = $clog2(RULES);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int SW    = $clog2(STACK_DEPTH + 1);
  localparam int LENW  = $clog2(MAX_RULE_LENGTH + 1);

  logic [5:0] tcount_r, tcount_nxt;
  logic [5:0] ncount_r, ncount_nxt;
  logic [4:0] start_r, start_nxt;
  logic [7:0] limit_r, limit_nxt;

  logic [1:0] cmd_r;
  logic [4:0] row_r, col_r, tok_r;
  logic [2:0] pos_r;
  logic [5:0] sym_r;
  logic [3:0] len_r;
  logic       has_r;

  logic [SW-1:0]   sp_r, sp_nxt;
  logic            active_r, active_nxt;
  logic [7:0]      exps_r, exps_nxt;
  logic [LENW-1:0] i_r, i_nxt;
  logic [CAW-1:0]  cell_r, clr_addr_r, clr_addr_nxt;

  logic            out_valid_r;
  logic [2:0]      out_status_r;
  logic [7:0]      out_expansions_r;
  logic [6:0]      out_stack_level_r;

  logic [31:0]     tcnt, ncnt;
  logic            cell_ok;
  logic [CAW-1:0]  in_cell, top_cell;
  logic [LENW-1:0] len_sat;

  logic            stk_we;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [5:0]      stk_wdata, stk_rdata;
  logic            cel_we;
  logic [CAW-1:0]  cel_waddr;
  logic [LENW:0]   cel_wdata, cel_rdata;
  logic            rul_we;
  logic [RAW-1:0]  rul_waddr, rul_raddr;
  logic [5:0]      rul_rdata;

  // Configuration registers.
  always_comb begin
    tcount_nxt = tcount_r;
    ncount_nxt = ncount_r;
    start_nxt  = start_r;
    limit_nxt  = limit_r;
    if (cfg_valid) begin
      if (cfg_index == REG_TCOUNT) tcount_nxt = cfg_data[5:0];
      if (cfg_index == REG_NCOUNT) ncount_nxt = cfg_data[5:0];
      if (cfg_index == REG_START)  start_nxt  = cfg_data[4:0];
      if (cfg_index == REG_LIMIT)  limit_nxt  = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcount_r <= RST_TCOUNT;
      ncount_r <= RST_NCOUNT;
      start_r  <= RST_START;
      limit_r  <= RST_LIMIT;
    end else begin
      tcount_r <= tcount_nxt;
      ncount_r <= ncount_nxt;
      start_r  <= start_nxt;
      limit_r  <= limit_nxt;
    end
  end

  assign tcnt = (32'(tcount_r) > 32'(MAX_TERMINALS)) ? 32'(MAX_TERMINALS) : 32'(tcount_r);
  assign ncnt = (32'(ncount_r) > 32'(MAX_NONTERMINALS)) ?
                32'(MAX_NONTERMINALS) : 32'(ncount_r);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= in_cmd;
      row_r <= in_row_nonterminal;
      col_r <= in_column_terminal;
      pos_r <= in_rule_position;
      sym_r <= in_rule_symbol;
      len_r <= in_rule_length;
      has_r <= in_has_rule;
      tok_r <= in_token;
    end
    if (cmd.cell_rd) begin
      cell_r <= top_cell;
    end
  end

  assign cell_ok = (32'(row_r) < 32'(MAX_NONTERMINALS)) && (32'(col_r) < 32'(MAX_TERMINALS));
  assign in_cell = CAW'(32'(row_r) * 32'(MAX_TERMINALS) + 32'(col_r));
  assign top_cell = CAW'(32'(stk_rdata[4:0]) * 32'(MAX_TERMINALS) + 32'(tok_r));
  assign len_sat = (32'(len_r) > 32'(MAX_RULE_LENGTH)) ?
                   LENW'(MAX_RULE_LENGTH) : LENW'(len_r);

  always_comb begin
    sp_nxt       = sp_r;
    active_nxt   = active_r;
    exps_nxt     = exps_r;
    i_nxt        = i_r;
    clr_addr_nxt = clr_addr_r;
    if (cmd.stk_init1) begin
      sp_nxt     = SW'(2);
      active_nxt = 1'b1;
    end
    if (cmd.pop)     sp_nxt = sp_r - SW'(1);
    if (cmd.push_wr) begin
      sp_nxt = sp_r + SW'(1);
      i_nxt  = i_r - LENW'(1);
    end
    if (cmd.end_parse) active_nxt = 1'b0;
    if (cmd.latch_in)  exps_nxt = 8'd0;
    if (cmd.exp_inc)   exps_nxt = exps_r + 8'd1;
    if (cmd.load_i)    i_nxt = cel_rdata[LENW-1:0];
    if (cmd.clr_wr)    clr_addr_nxt = clr_addr_r + CAW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      active_r    <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r        <= sp_nxt;
      active_r    <= active_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    exps_r <= exps_nxt;
    i_r    <= i_nxt;
    if (cmd.emit) begin
      out_status_r      <= cmd.emit_status;
      out_expansions_r  <= exps_nxt;
      out_stack_level_r <= 7'(32'(sp_nxt));
    end
  end

  // Symbol stack.
  assign stk_we    = cmd.stk_init0 | cmd.stk_init1 | cmd.push_wr;
  assign stk_waddr = cmd.stk_init0 ? SAW'(0) : (cmd.stk_init1 ? SAW'(1) : SAW'(sp_r));
  assign stk_wdata = cmd.stk_init0 ? END_MARK : (cmd.stk_init1 ? {1'b1, start_r} : rul_rdata);
  assign stk_raddr = SAW'(sp_r - SW'(1));

  llp_ram #(.WIDTH(6), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Cell info: rule flag over length.
  assign cel_we    = cmd.clr_wr | (cmd.tbl_write && cmd_r == CMD_CELL_LEN && cell_ok);
  assign cel_waddr = cmd.clr_wr ? clr_addr_r : in_cell;
  assign cel_wdata = cmd.clr_wr ? '0 : {has_r, len_sat};

  llp_ram #(.WIDTH(LENW + 1), .DEPTH(CELLS)) u_cells (
    .clk(clk), .we(cel_we), .waddr(cel_waddr), .wdata(cel_wdata),
    .raddr(top_cell), .rdata(cel_rdata)
  );

  // Production symbols.
  assign rul_we = cmd.tbl_write && cmd_r == CMD_RULE_SYM && cell_ok &&
                  (32'(pos_r) < 32'(MAX_RULE_LENGTH));
  assign rul_waddr = RAW'(32'(in_cell) * 32'(MAX_RULE_LENGTH) + 32'(pos_r));
  assign rul_raddr = RAW'(32'(cell_r) * 32'(MAX_RULE_LENGTH) + 32'(i_r) - 32'd1);

  llp_ram #(.WIDTH(6), .DEPTH(RULES)) u_rules (
    .clk(clk), .we(rul_we), .waddr(rul_waddr), .wdata(sym_r),
    .raddr(rul_raddr), .rdata(rul_rdata)
  );

  always_comb begin
    sts.cmd          = cmd_r;
    sts.active       = active_r;
    sts.tok_bad      = 32'(tok_r) >= tcnt;
    sts.sp_zero      = sp_r == '0;
    sts.top_is_nt    = stk_rdata[5];
    sts.top_bad      = stk_rdata[5] ? (32'(stk_rdata[4:0]) >= ncnt)
                                    : (32'(stk_rdata[4:0]) >= tcnt);
    sts.top_mismatch = stk_rdata[4:0] != tok_r;
    sts.top_end      = stk_rdata == END_MARK;
    sts.limit_hit    = exps_r >= limit_r;
    sts.no_rule      = !cel_rdata[LENW];
    sts.overflow     = (32'(sp_r) - 32'd1 + 32'(cel_rdata[LENW-1:0])) > 32'(STACK_DEPTH);
    sts.i_zero       = i_r == '0;
    sts.clr_done     = 32'(clr_addr_r) == 32'(CELLS - 1);
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_expansions  = out_expansions_r;
  assign out_stack_level = out_stack_level_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> 32'(sp_r) < 32'(STACK_DEPTH)) else $error("push beyond stack depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> sp_r != '0) else $error("pop from empty stack");
  a_exp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exp_inc |-> exps_r < limit_r) else $error("expansion past limit");
endmodule

### design/llp_ctrl.sv
`timescale 1ns / 1ps
module llp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  llp_pkg::llp_sts_t sts,
  output llp_pkg::llp_cmd_t cmd
);
  import llp_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_TOP   = 4'd5;
  localparam logic [3:0] S_CELL  = 4'd6;
  localparam logic [3:0] S_PUSH  = 4'd7;
  localparam logic [3:0] S_PUSHW = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        priority if (sts.cmd == CMD_RULE_SYM || sts.cmd == CMD_CELL_LEN) begin
          cmd.tbl_write   = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
        end else if (sts.cmd == CMD_START) begin
          cmd.stk_init0 = 1'b1;
          state_nxt     = S_INIT;
        end else if (!sts.active) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_IDLE;
        end else if (sts.tok_bad) begin
          cmd.emit        = 1'b1;
          cmd.end_parse   = 1'b1;
          cmd.emit_status = ST_UNKNOWN;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_INIT: begin
        cmd.stk_init1   = 1'b1;
        cmd.emit        = 1'b1;
        cmd.emit_status = ST_OK;
        state_nxt       = S_IDLE;
      end
      S_READ: begin
        if (sts.sp_zero) begin
          cmd.emit        = 1'b1;
          cmd.end_parse   = 1'b1;
          cmd.emit_status = ST_MISMATCH;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        state_nxt     = S_IDLE;
        cmd.emit      = 1'b1;
        cmd.end_parse = 1'b1;
        priority if (sts.top_bad) begin
          cmd.emit_status = ST_UNKNOWN;
        end else if (!sts.top_is_nt && sts.top_mismatch) begin
          cmd.emit_status = ST_MISMATCH;
        end else if (!sts.top_is_nt && sts.top_end) begin
          cmd.emit_status = ST_ACCEPT;
        end else if (!sts.top_is_nt) begin
          cmd.end_parse   = 1'b0;
          cmd.pop         = 1'b1;
          cmd.emit_status = ST_OK;
        end else if (sts.limit_hit) begin
          cmd.emit_status = ST_LIMIT;
        end else begin
          cmd.emit      = 1'b0;
          cmd.end_parse = 1'b0;
          cmd.cell_rd   = 1'b1;
          state_nxt     = S_CELL;
        end
      end
      S_CELL: begin
        priority if (sts.no_rule) begin
          cmd.emit        = 1'b1;
          cmd.end_parse   = 1'b1;
          cmd.emit_status = ST_NORULE;
          state_nxt       = S_IDLE;
        end else if (sts.overflow) begin
          cmd.emit        = 1'b1;
          cmd.end_parse   = 1'b1;
          cmd.emit_status = ST_OVERFLOW;
          state_nxt       = S_IDLE;
        end else begin
          cmd.pop    = 1'b1;
          cmd.load_i = 1'b1;
          state_nxt  = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.i_zero) begin
          cmd.exp_inc = 1'b1;
          state_nxt   = S_READ;
        end else begin
          state_nxt = S_PUSHW;
        end
      end
      S_PUSHW: begin
        cmd.push_wr = 1'b1;
        state_nxt   = S_PUSH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;
endmodule
